FILE: src/npt_pkg.sv
// Package for the nearest point table: field widths, request codes and
// controller state type. No dependencies.
`default_nettype none

package npt_pkg;

    localparam int MAX_POINTS_DEF = 64;

    localparam int COORD_W   = 16;   // x_pos / y_pos
    localparam int IDX_OUT_W = 6;    // entry_index field
    localparam int CNT_OUT_W = 7;    // point_count field
    localparam int DIST_W    = 17;   // distance field (root)
    localparam int SQ_W      = 32;   // one squared coordinate difference
    localparam int D2_W      = 33;   // squared distance
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_FIND   = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SHIFT,
        ST_SQRT,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: src/npt_sqrt.sv
// Iterative floor square root, one root bit per cycle.
// Depends on npt_pkg for the radicand and root widths.
`default_nettype none

module npt_sqrt (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [npt_pkg::D2_W-1:0]   i_radicand,
    output logic                            o_valid,
    output logic [npt_pkg::DIST_W-1:0]      o_root
);
    import npt_pkg::*;

    localparam int RAD_W  = 2 * DIST_W;
    localparam int REM_W  = DIST_W + 3;
    localparam int STEP_W = $clog2(DIST_W);

    logic              r_busy;
    logic              r_valid;
    logic [STEP_W-1:0] r_step;
    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [DIST_W-1:0] r_root;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    // bring down the next two radicand bits, try (4*root + 1)
    assign rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == STEP_W'(DIST_W - 1)) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= '0;
            r_rad  <= {{(RAD_W - D2_W){1'b0}}, i_radicand};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= take ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[DIST_W-2:0], take};
        end
    end

    assign o_valid = r_valid;
    assign o_root  = r_root;

endmodule

`default_nettype wire

FILE: src/nearest_point_table.sv
// Nearest point table top level: point memory, request controller, scan
// datapath and output register. Depends on npt_pkg and npt_sqrt.
//
// Usage:
//   Requests enter on s_axis (tuser = request code, tdata = x, y); one result
//   per request leaves on m_axis (tuser = ok, tdata = index, distance, count).
//   The block works on one request at a time; s_axis_tready is high only
//   while the controller is idle.
//   Steps from input transfer to result valid, with n stored points:
//     append, clear, and find or delete on an empty table: no scan
//     find: one memory read per point through the scan pipeline, then the
//           bit-serial square root
//     delete: scan up to the match, then move the later points down to close
//     the gap, one read and one write per cycle; no match: scan all n points
//   The memory port does one read and one write per cycle and sets the scan
//   rate. A finished result sits in the output register; if m_axis_tready is
//   low the controller holds until that register frees, then returns to idle.
//   Reset empties the table (count only, memory is not cleared) and drops
//   any pending result.
`default_nettype none

module nearest_point_table #(
    parameter int MAX_POINTS = npt_pkg::MAX_POINTS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // s_axis_tuser: [1:0] req_type
    // s_axis_tdata: [15:0] x_pos, [31:16] y_pos
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [1:0]                       s_axis_tuser,
    input  wire logic [npt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // m_axis_tuser: [0] ok
    // m_axis_tdata: [5:0] entry_index, [22:6] distance, [29:23] point_count,
    //               [31:30] zero
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic                                  m_axis_tuser,
    output logic [npt_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);
    import npt_pkg::*;

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int PT_W  = 2 * COORD_W;

    // point memory, {y, x} per entry
    logic [PT_W-1:0] mem [MAX_POINTS];
    logic [PT_W-1:0] r_rd_data;

    t_state r_state, n_state;

    t_req                r_req;
    logic [COORD_W-1:0]  r_qx, r_qy;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_ptr;

    logic                r_v1, r_v2;
    logic [IDX_W-1:0]    r_i1, r_i2;
    logic [SQ_W-1:0]     r_sqx, r_sqy;
    logic [D2_W-1:0]     r_best;

    logic                r_res_ok;
    logic [IDX_W-1:0]    r_res_idx;
    logic [DIST_W-1:0]   r_res_dist;

    logic                r_m_valid;
    logic                r_m_ok;
    logic [OUT_DATA_W-1:0] r_m_data;

    // control from the output decoder
    logic              rd_en;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [PT_W-1:0]   wr_data;
    logic              sqrt_start;
    logic              out_load;

    logic              in_xfer;
    logic              out_free;
    logic              cnt_full;
    logic              del_match;
    logic              scan_end;
    logic              shift_end;
    logic [D2_W-1:0]   d2;
    logic              better;

    logic signed [COORD_W:0]     dx, dy;
    logic signed [2*COORD_W+1:0] px, py;

    logic              sq_valid;
    logic [DIST_W-1:0] sq_root;

    logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;
    logic [IDX_W+IDX_OUT_W-1:0] idx_ext;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_m_valid || m_axis_tready;
    assign cnt_full  = (r_cnt == CNT_W'(MAX_POINTS));
    assign del_match = (r_state == ST_SCAN) && r_v1 && (r_req == REQ_DELETE)
                       && (r_rd_data == {r_qy, r_qx});
    assign scan_end  = (r_ptr == r_cnt) && !r_v1 && !r_v2;
    assign shift_end = (r_ptr == r_cnt) && !r_v1;

    // squared distance datapath: squares registered, then sum and compare
    assign dx = $signed({r_rd_data[COORD_W-1], r_rd_data[COORD_W-1:0]})
              - $signed({r_qx[COORD_W-1], r_qx});
    assign dy = $signed({r_rd_data[PT_W-1], r_rd_data[PT_W-1:COORD_W]})
              - $signed({r_qy[COORD_W-1], r_qy});
    assign px = dx * dx;
    assign py = dy * dy;
    assign d2 = {1'b0, r_sqx} + {1'b0, r_sqy};
    // strict compare keeps the earliest entry on a tie
    assign better = !r_res_ok || (d2 < r_best);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if ((r_req == REQ_FIND || r_req == REQ_DELETE) && r_cnt != '0) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (del_match) begin
                    n_state = ST_SHIFT;
                end else if (scan_end) begin
                    n_state = (r_req == REQ_FIND) ? ST_SQRT : ST_DONE;
                end
            end
            ST_SHIFT: begin
                if (shift_end) n_state = ST_DONE;
            end
            ST_SQRT: begin
                if (sq_valid) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = r_cnt[IDX_W-1:0];
        wr_data       = {r_qy, r_qx};
        sqrt_start    = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_EXEC: begin
                wr_en = (r_req == REQ_APPEND) && !cnt_full;
            end
            ST_SCAN: begin
                rd_en      = (r_ptr < r_cnt) && !del_match;
                sqrt_start = scan_end && !del_match && (r_req == REQ_FIND);
            end
            ST_SHIFT: begin
                rd_en   = (r_ptr < r_cnt);
                // entry k+1 read last cycle moves down to k
                wr_en   = r_v1;
                wr_addr = r_i1 - 1'b1;
                wr_data = r_rd_data;
            end
            ST_SQRT: ;
            ST_DONE: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rd_data <= mem[r_ptr[IDX_W-1:0]];
        if (wr_en) mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= rd_en;
            r_v2    <= (r_state == ST_SCAN) && r_v1 && (r_req == REQ_FIND);
            if (r_state == ST_EXEC) begin
                if (r_req == REQ_APPEND && !cnt_full) r_cnt <= r_cnt + 1'b1;
                if (r_req == REQ_CLEAR) r_cnt <= '0;
            end
            if (r_state == ST_SHIFT && shift_end) r_cnt <= r_cnt - 1'b1;
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req <= t_req'(s_axis_tuser);
            r_qx  <= s_axis_tdata[COORD_W-1:0];
            r_qy  <= s_axis_tdata[PT_W-1:COORD_W];
        end
        if (rd_en) begin
            r_ptr <= r_ptr + 1'b1;
            r_i1  <= r_ptr[IDX_W-1:0];
        end
        r_sqx <= px[SQ_W-1:0];
        r_sqy <= py[SQ_W-1:0];
        r_i2  <= r_i1;
        if (sq_valid) r_res_dist <= sq_root;

        unique case (r_state)
            ST_EXEC: begin
                r_ptr      <= '0;
                r_res_dist <= '0;
                if (r_req == REQ_APPEND && !cnt_full) begin
                    r_res_ok  <= 1'b1;
                    r_res_idx <= r_cnt[IDX_W-1:0];
                end else begin
                    r_res_ok  <= (r_req == REQ_CLEAR);
                    r_res_idx <= '0;
                end
            end
            ST_SCAN: begin
                if (del_match) begin
                    r_res_ok  <= 1'b1;
                    r_res_idx <= r_i1;
                    r_ptr     <= CNT_W'(r_i1) + 1'b1;
                end else if (r_v2 && better) begin
                    r_res_ok  <= 1'b1;
                    r_res_idx <= r_i2;
                    r_best    <= d2;
                end
            end
            default: ;
        endcase

        if (out_load) begin
            r_m_ok   <= r_res_ok;
            r_m_data <= {{(OUT_DATA_W - IDX_OUT_W - DIST_W - CNT_OUT_W){1'b0}},
                         cnt_ext[CNT_OUT_W-1:0], r_res_dist, idx_ext[IDX_OUT_W-1:0]};
        end
    end

    assign cnt_ext = {{CNT_OUT_W{1'b0}}, r_cnt};
    assign idx_ext = {{IDX_OUT_W{1'b0}}, r_res_idx};

    npt_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (r_best),
        .o_valid    (sq_valid),
        .o_root     (sq_root)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_ok;
    assign m_axis_tdata  = r_m_data;

endmodule

`default_nettype wire
